// ===== rtl/core/fcull_pkg.sv =====
package fcull_pkg;

  localparam int NUM_PLANES          = 6;
  localparam int COORD_W             = 16;
  localparam int PLANE_W             = 64;
  localparam int CFG_IDX_W           = 3;
  localparam int COUNT_W             = 4;
  localparam int COUNT_MAX           = 15;
  localparam int PROD_W              = 32;
  localparam int SUM_W               = PROD_W + 2;
  localparam int TERMS               = 4;
  localparam int DEF_CORNERS_PER_BOX = 8;
  localparam int DEF_QUEUE_DEPTH     = 4;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR   = 3'd0,
    REG_FAR    = 3'd1,
    REG_LEFT   = 3'd2,
    REG_RIGHT  = 3'd3,
    REG_TOP    = 3'd4,
    REG_BOTTOM = 3'd5
  } cfg_reg_t;

  // One classified corner as it travels from the front part to the back part.
  typedef struct packed {
    logic                  last;
    logic [NUM_PLANES-1:0] outside;
  } flags_t;

endpackage

// ===== rtl/core/fcull_if.sv =====
interface fcull_corner_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fcull_pkg::COORD_W-1:0] corner_x;
  logic signed [fcull_pkg::COORD_W-1:0] corner_y;
  logic signed [fcull_pkg::COORD_W-1:0] corner_z;
  logic                                 last_corner;

  modport source (output valid, corner_x, corner_y, corner_z, last_corner, input ready);
  modport sink   (input valid, corner_x, corner_y, corner_z, last_corner, output ready);
endinterface

interface fcull_result_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

interface fcull_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [fcull_pkg::CFG_IDX_W-1:0]      index;
  logic [fcull_pkg::PLANE_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/fcull_front.sv =====
module fcull_front #(
  parameter int QUEUE_DEPTH = fcull_pkg::DEF_QUEUE_DEPTH,
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fcull_corner_if.sink          in_if,
  fcull_cfg_if.sink             cfg_if,
  input  logic [LVL_W-1:0]      q_level,
  output logic                  push,
  output fcull_pkg::flags_t     push_flags
);

  logic [fcull_pkg::PLANE_W-1:0] plane_r [fcull_pkg::NUM_PLANES];

  logic signed [fcull_pkg::PROD_W-1:0] prod_r [fcull_pkg::NUM_PLANES][fcull_pkg::TERMS];
  logic                                s1_v_r;
  logic                                s1_last_r;
  logic                                s2_v_r;
  fcull_pkg::flags_t                   s2_flags_r;
  fcull_pkg::flags_t                   s2_flags_nxt;
  logic [LVL_W:0]                      used;
  logic                                acc;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
        plane_r[p] <= '0;
      end
    end else if (cfg_if.valid &&
                 (cfg_if.index <= fcull_pkg::CFG_IDX_W'(fcull_pkg::REG_BOTTOM))) begin
      plane_r[cfg_if.index] <= cfg_if.data;
    end
  end

  // Credit check: items already in the two stages must still find room in the queue.
  assign used = (LVL_W+1)'(q_level) + (LVL_W+1)'(s1_v_r) + (LVL_W+1)'(s2_v_r);
  assign in_if.ready = used < (LVL_W+1)'(QUEUE_DEPTH);
  assign acc = in_if.valid && in_if.ready;

  // Stage one: the three normal products and the aligned distance for each plane.
  always_ff @(posedge clk) begin
    for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
      prod_r[p][0] <= $signed(plane_r[p][15:0])  * in_if.corner_x;
      prod_r[p][1] <= $signed(plane_r[p][31:16]) * in_if.corner_y;
      prod_r[p][2] <= $signed(plane_r[p][47:32]) * in_if.corner_z;
      prod_r[p][3] <= {{2{plane_r[p][63]}}, plane_r[p][63:48], 14'b0};
    end
    s1_last_r  <= in_if.last_corner;
    s2_flags_r <= s2_flags_nxt;
  end

  // Stage two: exact sum, only its sign is kept.
  always_comb begin
    logic signed [fcull_pkg::SUM_W-1:0] sum;
    sum = '0;
    s2_flags_nxt.last = s1_last_r;
    for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
      sum = fcull_pkg::SUM_W'(prod_r[p][0]) + fcull_pkg::SUM_W'(prod_r[p][1]) +
            fcull_pkg::SUM_W'(prod_r[p][2]) + fcull_pkg::SUM_W'(prod_r[p][3]);
      s2_flags_nxt.outside[p] = sum[fcull_pkg::SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
    end
  end

  assign push       = s2_v_r;
  assign push_flags = s2_flags_r;

endmodule

// ===== rtl/core/fcull_queue.sv =====
module fcull_queue #(
  parameter int QUEUE_DEPTH = fcull_pkg::DEF_QUEUE_DEPTH,
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fcull_pkg::flags_t push_flags,
  input  logic              pop,
  output logic              head_valid,
  output fcull_pkg::flags_t head_flags,
  output logic [LVL_W-1:0]  level
);

  fcull_pkg::flags_t  slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [LVL_W-1:0]   level_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      level_r <= level_r + LVL_W'(push) - LVL_W'(pop);
    end
  end

  assign head_valid = level_r != '0;
  assign head_flags = slot_r[rd_ptr_r];
  assign level      = level_r;

endmodule

// ===== rtl/core/fcull_back.sv =====
module fcull_back #(
  parameter int CORNERS_PER_BOX = fcull_pkg::DEF_CORNERS_PER_BOX
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  fcull_pkg::flags_t head_flags,
  output logic              pop,
  fcull_result_if.source    out_if
);

  logic [fcull_pkg::COUNT_W-1:0] count_r   [fcull_pkg::NUM_PLANES];
  logic [fcull_pkg::COUNT_W-1:0] count_inc [fcull_pkg::NUM_PLANES];
  logic                          hit;
  logic                          out_free;
  logic                          out_valid_r;
  logic                          visible_r;
  logic                          emit;

  always_comb begin
    hit = 1'b0;
    for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
      count_inc[p] = (head_flags.outside[p] &&
                      (count_r[p] != fcull_pkg::COUNT_W'(fcull_pkg::COUNT_MAX)))
                     ? count_r[p] + 1'b1 : count_r[p];
      hit = hit || (count_inc[p] == fcull_pkg::COUNT_W'(CORNERS_PER_BOX));
    end
  end

  // A last corner needs a free output slot, other corners never wait.
  assign out_free = !out_valid_r || out_if.ready;
  assign pop      = head_valid && (!head_flags.last || out_free);
  assign emit     = pop && head_flags.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
        count_r[p] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
          count_r[p] <= head_flags.last ? '0 : count_inc[p];
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      visible_r <= !hit;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.visible = visible_r;

endmodule

// ===== rtl/core/frustum_box_cull_unit.sv =====
// Channel   Dir  Payload                                        Word
// in_if     in   corner_x, corner_y, corner_z, last_corner      one box corner
// out_if    out  visible                                        one box verdict
// cfg_if    in   index (3 bits), data (64 bits)                 one plane register
//
// One corner word is taken every cycle in steady state. A corner passes the two
// front stages (products, then sum and sign, each registered) and then the queue
// and the counters; a box verdict is registered in the output register when its
// last corner leaves the queue. Reset (rst_n low, synchronous) clears the planes,
// the counters, the queue and the output valid flag. A stalled output blocks the
// queue only once a last-corner word reaches its head; in_if.ready drops once
// the queue and the two front stages together would exceed the queue depth.
module frustum_box_cull_unit #(
  parameter int CORNERS_PER_BOX = fcull_pkg::DEF_CORNERS_PER_BOX,
  parameter int QUEUE_DEPTH     = fcull_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  fcull_corner_if.sink   in_if,
  fcull_result_if.source out_if,
  fcull_cfg_if.sink      cfg_if
);

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic              push;
  fcull_pkg::flags_t push_flags;
  logic              pop;
  logic              head_valid;
  fcull_pkg::flags_t head_flags;
  logic [LVL_W-1:0]  level;

  // Front part: plane registers, dot products and the per-plane outside flags.
  fcull_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg_if     (cfg_if),
    .q_level    (level),
    .push       (push),
    .push_flags (push_flags)
  );

  // The queue lets the front keep running while the result side is stalled.
  fcull_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_flags (push_flags),
    .pop        (pop),
    .head_valid (head_valid),
    .head_flags (head_flags),
    .level      (level)
  );

  // Back part: saturating outside counters and the verdict register.
  fcull_back #(
    .CORNERS_PER_BOX (CORNERS_PER_BOX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_flags (head_flags),
    .pop        (pop),
    .out_if     (out_if)
  );

endmodule
